@@ design/hsvl_pkg.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB level converter: shared package
// Types and constants used by the stages of the HSV to RGB level pipeline.
// ---------------------------------------------------------------------------
package hsvl_pkg;

	// Field widths of the inputs, the hue fraction and the output levels.
	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int FRAC_W = 6;
	localparam int LEVEL_W = 4;

	// Every color component is carried as a numerator over 100 * 100 * 60.
	localparam int K_W = 13;
	localparam int NUM_W = 20;
	localparam int COMMON_DEN = 600000;

	localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;
	localparam logic [K_W-1:0] K_FULL = 13'd6000;

	// Reciprocal of 2 * COMMON_DEN: ceil(2^50 / 1200000). The quotient taken
	// from bit RECIP_SHIFT up is exact for every numerator the levels produce.
	localparam int RECIP_W = 30;
	localparam int RECIP_SHIFT = 50;
	localparam logic [RECIP_W-1:0] RECIP_M = 30'd938249923;

	typedef logic [2:0] sector_t;

	localparam sector_t SEC_R_TO_Y = 3'd0;
	localparam sector_t SEC_Y_TO_G = 3'd1;
	localparam sector_t SEC_G_TO_C = 3'd2;
	localparam sector_t SEC_C_TO_B = 3'd3;
	localparam sector_t SEC_B_TO_M = 3'd4;
	localparam sector_t SEC_M_TO_R = 3'd5;

	// Channel order within the numerator and level vectors.
	localparam int CH_RED = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE = 2;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [LEVEL_W-1:0] level_t;

	// Pipeline advance and the valid bit entering a stage.
	typedef struct packed {
		logic en;
		logic valid;
	} flow_t;

endpackage

@@ design/hsvl_front.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB level converter: input stage
// Clamps the inputs and splits the hue into a sector and a fraction.
// ---------------------------------------------------------------------------
module hsvl_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hsvl_pkg::flow_t                   flow,
	input  logic [hsvl_pkg::HUE_W-1:0]        hue_deg,
	input  logic [hsvl_pkg::PCT_W-1:0]        sat_pct,
	input  logic [hsvl_pkg::PCT_W-1:0]        val_pct,
	output logic                              valid_s1,
	output hsvl_pkg::sector_t                 sector_s1,
	output logic [hsvl_pkg::FRAC_W-1:0]       frac_s1,
	output logic [hsvl_pkg::PCT_W-1:0]        sat_s1,
	output logic [hsvl_pkg::PCT_W-1:0]        val_s1
);
	import hsvl_pkg::*;

	sector_t sector;
	logic [HUE_W-1:0] base;
	logic [PCT_W-1:0] sat_c;
	logic [PCT_W-1:0] val_c;

	// Hue at or above 360 lands in the last sector with no fraction.
	always_comb begin
		priority if (hue_deg >= HUE_MAX) begin
			sector = SEC_M_TO_R;
			base = hue_deg;
		end else if (hue_deg >= HUE_W'(5 * SECTOR_DEG)) begin
			sector = SEC_M_TO_R;
			base = HUE_W'(5 * SECTOR_DEG);
		end else if (hue_deg >= HUE_W'(4 * SECTOR_DEG)) begin
			sector = SEC_B_TO_M;
			base = HUE_W'(4 * SECTOR_DEG);
		end else if (hue_deg >= HUE_W'(3 * SECTOR_DEG)) begin
			sector = SEC_C_TO_B;
			base = HUE_W'(3 * SECTOR_DEG);
		end else if (hue_deg >= HUE_W'(2 * SECTOR_DEG)) begin
			sector = SEC_G_TO_C;
			base = HUE_W'(2 * SECTOR_DEG);
		end else if (hue_deg >= SECTOR_DEG) begin
			sector = SEC_Y_TO_G;
			base = SECTOR_DEG;
		end else begin
			sector = SEC_R_TO_Y;
			base = '0;
		end
	end

	assign sat_c = (sat_pct > PCT_MAX) ? PCT_MAX : sat_pct;
	assign val_c = (val_pct > PCT_MAX) ? PCT_MAX : val_pct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (flow.en) begin
			valid_s1 <= flow.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.en) begin
			sector_s1 <= sector;
			frac_s1 <= FRAC_W'(hue_deg - base);
			sat_s1 <= sat_c;
			val_s1 <= val_c;
		end
	end

`ifndef NO_ASSERTIONS
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sector_s1 <= SEC_M_TO_R) && (frac_s1 < FRAC_W'(SECTOR_DEG)))
		else $error("sector or fraction out of range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!flow.en |=> $stable(sector_s1) && $stable(frac_s1) && $stable(valid_s1))
		else $error("input stage changed while stalled");
`endif

endmodule

@@ design/hsvl_mix.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB level converter: component stages
// Forms p, q and t over a common denominator and routes them per sector.
// ---------------------------------------------------------------------------
module hsvl_mix (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hsvl_pkg::flow_t                        flow,
	input  hsvl_pkg::sector_t                      sector_s1,
	input  logic [hsvl_pkg::FRAC_W-1:0]            frac_s1,
	input  logic [hsvl_pkg::PCT_W-1:0]             sat_s1,
	input  logic [hsvl_pkg::PCT_W-1:0]             val_s1,
	output logic                                   valid_s3,
	output logic [2:0][hsvl_pkg::NUM_W-1:0]        num_s3
);
	import hsvl_pkg::*;

	logic valid_s2;
	sector_t sector_s2;
	logic [PCT_W-1:0] val_s2;
	logic [K_W-1:0] pk_s2;
	logic [K_W-1:0] qk_s2;
	logic [K_W-1:0] tk_s2;

	logic [K_W-1:0] sf;
	logic [K_W-1:0] sg;
	logic [K_W-1:0] s60;
	num_t nv;
	num_t np;
	num_t nq;
	num_t nt;
	logic [2:0][NUM_W-1:0] num;

	// Stage 2: saturation terms, each at most 6000.
	assign sf = K_W'(sat_s1) * K_W'(frac_s1);
	assign sg = K_W'(sat_s1) * K_W'(SECTOR_DEG - HUE_W'(frac_s1));
	assign s60 = K_W'(sat_s1) * K_W'(SECTOR_DEG);

	// Stage 3: scale by value and pick the channel order of the sector.
	assign nv = NUM_W'(val_s2) * NUM_W'(K_FULL);
	assign np = NUM_W'(val_s2) * NUM_W'(pk_s2);
	assign nq = NUM_W'(val_s2) * NUM_W'(qk_s2);
	assign nt = NUM_W'(val_s2) * NUM_W'(tk_s2);

	always_comb begin
		unique case (sector_s2)
			SEC_R_TO_Y: begin
				num[CH_RED] = nv; num[CH_GREEN] = nt; num[CH_BLUE] = np;
			end
			SEC_Y_TO_G: begin
				num[CH_RED] = nq; num[CH_GREEN] = nv; num[CH_BLUE] = np;
			end
			SEC_G_TO_C: begin
				num[CH_RED] = np; num[CH_GREEN] = nv; num[CH_BLUE] = nt;
			end
			SEC_C_TO_B: begin
				num[CH_RED] = np; num[CH_GREEN] = nq; num[CH_BLUE] = nv;
			end
			SEC_B_TO_M: begin
				num[CH_RED] = nt; num[CH_GREEN] = np; num[CH_BLUE] = nv;
			end
			default: begin
				num[CH_RED] = nv; num[CH_GREEN] = np; num[CH_BLUE] = nq;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (flow.en) begin
			valid_s2 <= flow.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.en) begin
			sector_s2 <= sector_s1;
			val_s2 <= val_s1;
			pk_s2 <= K_FULL - s60;
			qk_s2 <= K_FULL - sf;
			tk_s2 <= K_FULL - sg;
			num_s3 <= num;
		end
	end

`ifndef NO_ASSERTIONS
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (num_s3[CH_RED] <= NUM_W'(COMMON_DEN))
			&& (num_s3[CH_GREEN] <= NUM_W'(COMMON_DEN))
			&& (num_s3[CH_BLUE] <= NUM_W'(COMMON_DEN)))
		else $error("component numerator above the common denominator");
`endif

endmodule

@@ design/hsvl_level.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB level converter: rounding stages
// Scales each numerator to a drive level, rounding halves up, by a
// reciprocal multiply in place of a divide.
// ---------------------------------------------------------------------------
module hsvl_level #(
	parameter int LEVEL_SCALE = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hsvl_pkg::flow_t                        flow,
	input  logic [2:0][hsvl_pkg::NUM_W-1:0]        num_s3,
	output logic                                   valid_s5,
	output logic [2:0][hsvl_pkg::LEVEL_W-1:0]      level_s5
);
	import hsvl_pkg::*;

	localparam longint XMAX = 2 * longint'(LEVEL_SCALE) * COMMON_DEN + COMMON_DEN;
	localparam int XW = $clog2(XMAX + 1);
	localparam int PW = XW + RECIP_W;
	localparam logic [XW-1:0] SCALE2 = XW'(2 * LEVEL_SCALE);
	localparam logic [XW-1:0] BIAS = XW'(COMMON_DEN);

	logic valid_s4;
	logic [2:0][XW-1:0] x_s4;
	logic [2:0][PW-1:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (flow.en) begin
			valid_s4 <= flow.valid;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 4 forms 2 * scale * num + den; stage 5 multiplies by the
	// reciprocal of 2 * den, so the quotient sits above RECIP_SHIFT.
	always_ff @(posedge clk) begin
		if (flow.en) begin
			for (int i = 0; i < 3; i++) begin
				x_s4[i] <= XW'(num_s3[i]) * SCALE2 + BIAS;
				prod_s5[i] <= PW'(x_s4[i]) * PW'(RECIP_M);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			level_s5[i] = LEVEL_W'(prod_s5[i] >> RECIP_SHIFT);
		end
	end

endmodule

@@ design/hsv_to_rgb_level_converter_unit.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB level converter
// Converts hue, saturation and value into red, green and blue drive levels.
// ---------------------------------------------------------------------------
// Takes one color word per cycle, unless the sink holds the output, and returns
// red, green and blue levels of round(LEVEL_SCALE * component), halves rounded
// up, each kept to 4 bits. Hue is in degrees and clamps at 360, which maps to
// the last sector with no fraction; saturation and value are in percent and
// clamp at 100. The block is a five-stage pipeline (clamp and sector split,
// saturation products, value products with sector routing, scale and bias,
// reciprocal multiply), and a new word may enter every cycle unless the sink
// holds the output. The whole pipeline advances together; when the output word
// is held by the sink, input ready drops in the same cycle.
module hsv_to_rgb_level_converter_unit #(
	parameter int LEVEL_SCALE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // hue_deg[8:0], sat_pct[15:9], val_pct[22:16], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // red_level[3:0], green_level[7:4], blue_level[11:8], zero
);
	import hsvl_pkg::*;

	logic en;
	flow_t flow_in;
	flow_t flow_s1;
	flow_t flow_s3;

	logic valid_s1;
	sector_t sector_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [PCT_W-1:0] sat_s1;
	logic [PCT_W-1:0] val_s1;
	logic valid_s3;
	logic [2:0][NUM_W-1:0] num_s3;
	logic valid_s5;
	logic [2:0][LEVEL_W-1:0] level_s5;

	// The pipeline moves whenever the output register is empty or drained.
	assign en = !valid_s5 || m_tready;
	assign s_tready = en;

	assign flow_in = '{en: en, valid: s_tvalid};
	assign flow_s1 = '{en: en, valid: valid_s1};
	assign flow_s3 = '{en: en, valid: valid_s3};

	hsvl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow_in),
		.hue_deg   (s_tdata[8:0]),
		.sat_pct   (s_tdata[15:9]),
		.val_pct   (s_tdata[22:16]),
		.valid_s1  (valid_s1),
		.sector_s1 (sector_s1),
		.frac_s1   (frac_s1),
		.sat_s1    (sat_s1),
		.val_s1    (val_s1)
	);

	hsvl_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow_s1),
		.sector_s1 (sector_s1),
		.frac_s1   (frac_s1),
		.sat_s1    (sat_s1),
		.val_s1    (val_s1),
		.valid_s3  (valid_s3),
		.num_s3    (num_s3)
	);

	hsvl_level #(
		.LEVEL_SCALE (LEVEL_SCALE)
	) u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.flow     (flow_s3),
		.num_s3   (num_s3),
		.valid_s5 (valid_s5),
		.level_s5 (level_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata = {4'b0000, level_s5[CH_BLUE], level_s5[CH_GREEN], level_s5[CH_RED]};

`ifndef NO_ASSERTIONS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (LEVEL_SCALE > 15)
			|| ((int'(level_s5[CH_RED]) <= LEVEL_SCALE)
			&& (int'(level_s5[CH_GREEN]) <= LEVEL_SCALE)
			&& (int'(level_s5[CH_BLUE]) <= LEVEL_SCALE)))
		else $error("drive level above the level scale");
`endif

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB level converter testbench
// Streams color words through the converter and checks every returned word
// against levels computed here, with random idling on both stream sides.
// ---------------------------------------------------------------------------
module tb;
	import hsvl_pkg::*;

	localparam int LEVEL_SCALE = 8;
	localparam int RANDOM_ITEMS = 1700;
	localparam int TAIL_ITEMS = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		level_t blue;
		level_t green;
		level_t red;
	} rgb_levels_t;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] val;
		rgb_levels_t levels;
	} color_check_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [23:0] color_queue[$];
	color_check_t pending_levels[$];
	int total_words = 0;
	int words_in = 0;
	int words_out = 0;
	int clamped_words = 0;
	int error_count = 0;
	int src_hold = 0;
	int sink_hold = 0;
	int stall_cycles = 0;
	logic tail_phase = 1'b0;

	hsv_to_rgb_level_converter_unit #(
		.LEVEL_SCALE(LEVEL_SCALE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Rounded LEVEL_SCALE * num / COMMON_DEN with halves going up, kept to 4 bits.
	function automatic level_t round_level(longint unsigned num);
		longint unsigned scaled;
		scaled = 2 * LEVEL_SCALE * num + COMMON_DEN;
		return level_t'(scaled / (2 * COMMON_DEN));
	endfunction

	function automatic rgb_levels_t hsv_levels(logic [HUE_W-1:0] hue_in,
			logic [PCT_W-1:0] sat_in, logic [PCT_W-1:0] val_in);
		longint unsigned hue, sat, val, frac, nv, np, nq, nt;
		longint unsigned chan[3];
		sector_t sector;
		rgb_levels_t res;
		hue = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
		sat = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
		val = (val_in > PCT_MAX) ? PCT_MAX : val_in;
		// A hue of 360 stays in the magenta-to-red sector with no fraction.
		if (hue >= 6 * SECTOR_DEG) begin
			sector = SEC_M_TO_R;
			frac = 0;
		end else begin
			sector = sector_t'(hue / SECTOR_DEG);
			frac = hue % SECTOR_DEG;
		end
		nv = val * K_FULL;
		np = val * (PCT_MAX - sat) * SECTOR_DEG;
		nq = val * (K_FULL - sat * frac);
		nt = val * (K_FULL - sat * (SECTOR_DEG - frac));
		case (sector)
			SEC_R_TO_Y: begin
				chan[CH_RED] = nv; chan[CH_GREEN] = nt; chan[CH_BLUE] = np;
			end
			SEC_Y_TO_G: begin
				chan[CH_RED] = nq; chan[CH_GREEN] = nv; chan[CH_BLUE] = np;
			end
			SEC_G_TO_C: begin
				chan[CH_RED] = np; chan[CH_GREEN] = nv; chan[CH_BLUE] = nt;
			end
			SEC_C_TO_B: begin
				chan[CH_RED] = np; chan[CH_GREEN] = nq; chan[CH_BLUE] = nv;
			end
			SEC_B_TO_M: begin
				chan[CH_RED] = nt; chan[CH_GREEN] = np; chan[CH_BLUE] = nv;
			end
			default: begin
				chan[CH_RED] = nv; chan[CH_GREEN] = np; chan[CH_BLUE] = nq;
			end
		endcase
		res.red = round_level(chan[CH_RED]);
		res.green = round_level(chan[CH_GREEN]);
		res.blue = round_level(chan[CH_BLUE]);
		return res;
	endfunction

	function automatic logic [23:0] color_word(int hue, int sat, int val);
		logic [HUE_W-1:0] h;
		logic [PCT_W-1:0] s;
		logic [PCT_W-1:0] v;
		h = HUE_W'(hue);
		s = PCT_W'(sat);
		v = PCT_W'(val);
		return {1'b0, v, s, h};
	endfunction

	task automatic add_color(int hue, int sat, int val);
		color_queue.push_back(color_word(hue, sat, val));
		if (hue > HUE_MAX || sat > PCT_MAX || val > PCT_MAX)
			clamped_words++;
		total_words++;
	endtask

	task automatic check_field(string field, int exp_val, int act_val, color_check_t item);
		if (exp_val != act_val) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch for hue %0d sat %0d val %0d: expected %0d, got %0d",
					$time, field, item.hue, item.sat, item.val, exp_val, act_val);
		end
	endtask

	// Driver: presents queued color words and records what each accepted word should give.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_hold <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				color_check_t item;
				item.hue = s_tdata[8:0];
				item.sat = s_tdata[15:9];
				item.val = s_tdata[22:16];
				item.levels = hsv_levels(item.hue, item.sat, item.val);
				pending_levels.push_back(item);
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_hold != 0) begin
					src_hold <= src_hold - 1;
					s_tvalid <= 1'b0;
				end else if (color_queue.size() != 0) begin
					s_tdata <= color_queue.pop_front();
					s_tvalid <= 1'b1;
					if (color_queue.size() <= TAIL_ITEMS)
						tail_phase <= 1'b1;
					else if ($urandom_range(0, 5) == 0)
						src_hold <= $urandom_range(1, 10);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the output side in bursts and checks each returned word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				color_check_t item;
				words_out++;
				if (pending_levels.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected output word: expected none, got %h",
							$time, m_tdata);
				end else begin
					item = pending_levels.pop_front();
					check_field("red level", item.levels.red, m_tdata[3:0], item);
					check_field("green level", item.levels.green, m_tdata[7:4], item);
					check_field("blue level", item.levels.blue, m_tdata[11:8], item);
					check_field("padding", 0, m_tdata[15:12], item);
				end
			end
			if (sink_hold != 0) begin
				sink_hold <= sink_hold - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!tail_phase && $urandom_range(0, 7) == 0)
					sink_hold <= $urandom_range(1, 10);
			end
		end
	end

	initial begin
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int mode, hue, sat, val;
		// Directed colors: primaries and secondaries, sector edges, clamping,
		// grey, black and an exact half that must round up.
		add_color(0, 100, 100);
		add_color(60, 100, 100);
		add_color(120, 100, 100);
		add_color(180, 100, 100);
		add_color(240, 100, 100);
		add_color(300, 100, 100);
		add_color(359, 100, 100);
		add_color(360, 100, 100);
		add_color(361, 100, 100);
		add_color(511, 127, 127);
		add_color(30, 0, 50);
		add_color(0, 0, 0);
		add_color(0, 75, 25);
		add_color(59, 100, 100);
		add_color(1, 1, 1);
		add_color(200, 101, 100);
		add_color(90, 50, 127);
		add_color(330, 64, 64);
		add_color(255, 63, 63);
		add_color(256, 100, 1);
		add_color(45, 100, 100);
		add_color(150, 37, 88);
		add_color(210, 99, 12);
		add_color(270, 50, 50);
		add_color(0, 100, 0);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = $urandom_range(0, 19);
			if (mode < 3) begin
				hue = $urandom_range(0, 511);
				sat = $urandom_range(0, 127);
				val = $urandom_range(0, 127);
			end else if (mode < 6) begin
				hue = 60 * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
				if (hue < 0)
					hue = 0;
				sat = ($urandom_range(0, 1) != 0) ? 100 : $urandom_range(0, 100);
				val = ($urandom_range(0, 1) != 0) ? 100 : $urandom_range(0, 100);
			end else if (mode == 6) begin
				hue = $urandom_range(0, 360);
				sat = 0;
				val = $urandom_range(0, 100);
			end else begin
				hue = $urandom_range(0, 360);
				sat = $urandom_range(0, 100);
				val = $urandom_range(0, 100);
			end
			add_color(hue, sat, val);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_in != total_words || pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d colors (%0d with out-of-range fields), %0d words returned.",
			words_in, clamped_words, words_out);
		$display("Source and sink idled in random bursts, then ran without gaps at the end.");
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
